>>> hdl/csso_pkg.sv
// Shared constants and item types for the C-SCAN seek order unit.
package csso_pkg;

	localparam int MAX_REQUESTS = 16;
	localparam int TRACK_W      = 16;
	localparam int TOTAL_W      = 21;
	localparam int TT_W         = TRACK_W + 1;
	localparam int DEPTH        = MAX_REQUESTS + 3;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = TT_W;

	localparam logic [CFG_IDX_W-1:0] REG_HEAD_POSITION = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_TOTAL   = CFG_IDX_W'(1);

	typedef struct packed {
		logic [TRACK_W-1:0] request_track;
		logic               batch_end;
	} req_item_t;

	typedef struct packed {
		logic [TRACK_W-1:0] visit_track;
		logic [TRACK_W-1:0] step_distance;
		logic [TOTAL_W-1:0] total_movement;
		logic               final_visit;
	} visit_item_t;

endpackage

>>> hdl/cscan_seek_order_unit.sv
// Top level of the C-SCAN seek order unit: request sorting memory and its sequencer.
//
// The unit collects a batch of track requests, one item at a time, and keeps
// them in ascending order in a small synchronous memory by insertion. A
// request above the last track is saturated to the last track, and requests
// beyond the sixteenth of a batch are dropped (their batch_end flag still
// counts). The request that carries batch_end also inserts track 0, the head
// position and the last track, then the unit searches for the first entry
// equal to the head and emits the service order: from the head upward to the
// last track, a wrap to track 0 (counted as movement) and a climb to just
// below the head. Each result item carries the visited track, the distance
// from the previous visit (0 for the first), the running total and a flag on
// the last result; a batch of k stored requests yields k + 3 results.
// Timing: all work goes through one memory with one read and one write port
// and a registered read, so each compare step passes a read state and a
// compare state. An insertion walks down from the top of the store, moving
// each entry above the new value up by one, and the unit is ready again once
// the value is written. On batch end the three fixed points take the same
// kind of insertion each, the head search reads entries upward from the bottom
// up to and including the head, and emission reads each result and loads it
// into the output register, waiting while the output side holds it back. The
// output register lets a finished result wait while the next batch's requests
// are already being taken. The configuration port is always ready; index 0
// writes head_position, index 1 writes track_total, other indexes are ignored.
module cscan_seek_order_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  csso_pkg::req_item_t           in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output csso_pkg::visit_item_t         out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [csso_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csso_pkg::CFG_DATA_W-1:0] cfg_data
);
	import csso_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_EMIT_RD,
		S_EMIT_WR
	} state_t;

	// Which value the insertion engine is currently placing.
	typedef enum logic [1:0] {
		P_REQ,
		P_ZERO,
		P_HEAD,
		P_LAST
	} phase_t;

	state_t              state_q;
	phase_t              phase_q;
	logic [TRACK_W-1:0]  head_q;
	logic [TT_W-1:0]     track_total_q;
	logic [CNT_W-1:0]    count_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic [TRACK_W-1:0]  value_q;
	logic                end_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [CNT_W-1:0]    visit_n_q;
	logic [TRACK_W-1:0]  prev_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                out_valid_q;
	visit_item_t         out_q;

	// Sorted track store.
	logic [TRACK_W-1:0]  track_mem [DEPTH];
	logic [TRACK_W-1:0]  rdata_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [TRACK_W-1:0]  mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;

	logic [TT_W-1:0]     tt_minus1;
	logic [TRACK_W-1:0]  last_track;
	logic [TRACK_W-1:0]  req_sat;
	logic                ins_done;
	logic [CNT_W-1:0]    count_inc;
	logic [TRACK_W-1:0]  step_dist;
	logic                is_final;
	logic [CNT_W-1:0]    idx_inc;
	logic                out_free;

	// Last track: one track when the total is zero, clipped to the track width.
	always_comb begin
		tt_minus1 = track_total_q - TT_W'(1);
		if (track_total_q == '0) begin
			last_track = '0;
		end else if (tt_minus1 > TT_W'({TRACK_W{1'b1}})) begin
			last_track = {TRACK_W{1'b1}};
		end else begin
			last_track = tt_minus1[TRACK_W-1:0];
		end
		req_sat = (in_data.request_track > last_track) ? last_track : in_data.request_track;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign count_inc = count_q + CNT_W'(1);
	assign idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
	assign is_final  = (visit_n_q + CNT_W'(1)) == count_q;

	always_comb begin
		if (visit_n_q == '0) begin
			step_dist = '0;
		end else if (rdata_q >= prev_q) begin
			step_dist = rdata_q - prev_q;
		end else begin
			step_dist = prev_q - rdata_q;
		end
	end

	// Memory port control for insertion, search and emission.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = value_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q - ADDR_W'(1);
		ins_done  = 1'b0;
		case (state_q)
			S_INS_RD: begin
				if (ptr_q == '0) begin
					mem_we   = 1'b1;
					ins_done = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				if (rdata_q > value_q) begin
					mem_wdata = rdata_q;
				end else begin
					ins_done = 1'b1;
				end
			end
			S_SRCH_RD: begin
				mem_re    = 1'b1;
				mem_raddr = ptr_q;
			end
			S_EMIT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			track_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= track_mem[mem_raddr];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			track_total_q <= TT_W'(1) << TRACK_W;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_HEAD_POSITION) begin
				head_q <= cfg_data[TRACK_W-1:0];
			end else if (cfg_index == REG_TRACK_TOTAL) begin
				track_total_q <= cfg_data;
			end
		end
	end

	// Sequencer with its registered output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= P_REQ;
			count_q     <= '0;
			ptr_q       <= '0;
			value_q     <= '0;
			end_q       <= 1'b0;
			idx_q       <= '0;
			visit_n_q   <= '0;
			prev_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						end_q <= in_data.batch_end;
						ptr_q <= count_q[ADDR_W-1:0];
						if (count_q < CNT_W'(MAX_REQUESTS)) begin
							phase_q <= P_REQ;
							value_q <= req_sat;
							state_q <= S_INS_RD;
						end else if (in_data.batch_end) begin
							// A full batch drops the request but still closes.
							phase_q <= P_ZERO;
							value_q <= '0;
							state_q <= S_INS_RD;
						end
					end
				end
				S_INS_RD: begin
					if (!ins_done) begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (!ins_done) begin
						ptr_q   <= ptr_q - ADDR_W'(1);
						state_q <= S_INS_RD;
					end
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (rdata_q == head_q) begin
						idx_q     <= ptr_q;
						visit_n_q <= '0;
						state_q   <= S_EMIT_RD;
					end else begin
						ptr_q   <= ptr_q + ADDR_W'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						out_q.visit_track    <= rdata_q;
						out_q.step_distance  <= step_dist;
						out_q.total_movement <= total_q + TOTAL_W'(step_dist);
						out_q.final_visit    <= is_final;
						total_q              <= total_q + TOTAL_W'(step_dist);
						prev_q               <= rdata_q;
						visit_n_q            <= visit_n_q + CNT_W'(1);
						idx_q                <= (idx_inc == count_q) ? '0 : idx_inc[ADDR_W-1:0];
						if (is_final) begin
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// End of one insertion: count it and pick the next value to place.
			if (ins_done) begin
				count_q <= count_inc;
				ptr_q   <= count_inc[ADDR_W-1:0];
				state_q <= S_INS_RD;
				case (phase_q)
					P_REQ: begin
						if (end_q) begin
							phase_q <= P_ZERO;
							value_q <= '0;
						end else begin
							state_q <= S_IDLE;
						end
					end
					P_ZERO: begin
						phase_q <= P_HEAD;
						value_q <= head_q;
					end
					P_HEAD: begin
						phase_q <= P_LAST;
						value_q <= last_track;
					end
					P_LAST: begin
						total_q <= '0;
						ptr_q   <= '0;
						state_q <= S_SRCH_RD;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	// The stored count never passes the batch limit between items.
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (count_q <= CNT_W'(MAX_REQUESTS)))
		else $error("request count above batch limit while idle");

	// While results go out, the store holds at least the three fixed points.
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_WR) |-> (count_q >= CNT_W'(3)))
		else $error("emission with fewer than three stored tracks");

	// The running total always covers the latest step.
	a_total_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.total_movement >= TOTAL_W'(out_data.step_distance)))
		else $error("running total below step distance");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the C-SCAN seek order unit: directed table, then random batches.
`timescale 1ns / 100ps

module testbench;
	import csso_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 320;
	// Quiet time before a register write or the end of the run. It covers any
	// request that was still being sorted when the last result came out.
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [TRACK_W-1:0]   TRACK_TOP = '1;
	// An index that decodes to no register; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;
	typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_mode_e;

	// One row of the directed table: either a register write or a request.
	// Rows with typed_results set take their expected visits from the
	// hand-written list below instead of from the predictor.
	typedef struct packed {
		row_kind_e             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		req_item_t             rq;
		logic [4:0]            typed_results;
	} stim_row_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          in_ready;
	req_item_t     in_data   = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	visit_item_t   out_data;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Predictor state: the register copies and the requests of the open batch,
	// kept in ascending order just like the unit's sorting memory.
	logic [TRACK_W-1:0] head_track  = '0;
	logic [TT_W-1:0]    track_count = TT_W'(17'h10000);
	logic [TRACK_W-1:0] held_tracks[$];
	visit_item_t        pending_visits[$];
	visit_item_t        want;

	int mismatch_count = 0;
	int cycle_count    = 0;
	int burst_left     = 0;
	int known_next     = 0;

	rx_mode_e rx_mode  = RX_OPEN;
	int       rx_span  = 0;
	int       rx_tick  = 0;

	// Directed part. After reset the head is 0 and the disk has 65536 tracks.
	// Then a one-track disk with the head far above it (requests saturate to 0),
	// a zero track total (also one track), an oversized track total with a full
	// batch whose seventeenth request is dropped but still ends the batch, and
	// finally a write to an unused index that must be ignored, then one more batch.
	stim_row_t directed_rows [0:32] = '{
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h0000, 1'b1}, 5'd4},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'hFFFF, 1'b1}, 5'd4},
		'{ROW_CFG, REG_HEAD_POSITION, 17'h0FFFF, '0, 5'd0},
		'{ROW_CFG, REG_TRACK_TOTAL, 17'h00001, '0, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'hFFFF, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'hAAAA, 1'b1}, 5'd5},
		'{ROW_CFG, REG_HEAD_POSITION, 17'h00000, '0, 5'd0},
		'{ROW_CFG, REG_TRACK_TOTAL, 17'h00000, '0, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h5555, 1'b1}, 5'd4},
		'{ROW_CFG, REG_TRACK_TOTAL, 17'h1FFFF, '0, 5'd0},
		'{ROW_CFG, REG_HEAD_POSITION, 17'h08000, '0, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h8000, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'hFFFF, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h0000, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h8000, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h7FFF, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h8001, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h0001, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'hFFFE, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h1234, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'hC000, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h4000, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h8000, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'hFFFF, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h0000, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h5A5A, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'hA5A5, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h3C3C, 1'b1}, 5'd0},
		'{ROW_CFG, REG_HEAD_POSITION, 17'h01234, '0, 5'd0},
		'{ROW_CFG, REG_TRACK_TOTAL, 17'h00100, '0, 5'd0},
		'{ROW_CFG, REG_SPARE, 17'h00005, '0, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h0300, 1'b0}, 5'd0},
		'{ROW_REQ, REG_HEAD_POSITION, '0, '{16'h00FF, 1'b1}, 5'd0}
	};

	// Visits for the typed rows, in order: batch {0} and batch {65535} at reset,
	// the one-track disk with the head at 65535, and the zero track total.
	visit_item_t known_visits [0:16] = '{
		'{16'h0000, 16'h0000, 21'd0, 1'b0},
		'{16'h0000, 16'h0000, 21'd0, 1'b0},
		'{16'h0000, 16'h0000, 21'd0, 1'b0},
		'{16'hFFFF, 16'hFFFF, 21'd65535, 1'b1},
		'{16'h0000, 16'h0000, 21'd0, 1'b0},
		'{16'h0000, 16'h0000, 21'd0, 1'b0},
		'{16'hFFFF, 16'hFFFF, 21'd65535, 1'b0},
		'{16'hFFFF, 16'h0000, 21'd65535, 1'b1},
		'{16'hFFFF, 16'h0000, 21'd0, 1'b0},
		'{16'h0000, 16'hFFFF, 21'd65535, 1'b0},
		'{16'h0000, 16'h0000, 21'd65535, 1'b0},
		'{16'h0000, 16'h0000, 21'd65535, 1'b0},
		'{16'h0000, 16'h0000, 21'd65535, 1'b1},
		'{16'h0000, 16'h0000, 21'd0, 1'b0},
		'{16'h0000, 16'h0000, 21'd0, 1'b0},
		'{16'h0000, 16'h0000, 21'd0, 1'b0},
		'{16'h0000, 16'h0000, 21'd0, 1'b1}
	};

	cscan_seek_order_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// The last track for a given track total: a zero total still means one
	// track, and a total beyond the track width is clipped to the top track.
	function automatic logic [TRACK_W-1:0] last_track_for(input logic [TT_W-1:0] tt);
		logic [TT_W-1:0] last_wide;
		last_wide = (tt == '0) ? '0 : tt - 1'b1;
		return (last_wide > {1'b0, TRACK_TOP}) ? TRACK_TOP : last_wide[TRACK_W-1:0];
	endfunction

	// Predictor. Sorts the request into the open batch (unless the batch is
	// full), and on the batch end merges in track 0, the head and the last
	// track, then walks the list from the first entry equal to the head,
	// wrapping once around to just below it.
	task automatic predict_visits(input req_item_t rq, input bit keep);
		logic [TRACK_W-1:0] last, req, prev, cur, step_dist;
		logic [TRACK_W-1:0] order[$];
		logic [TRACK_W-1:0] fixed_points[3];
		logic [TOTAL_W-1:0] total;
		visit_item_t v;
		int idx, f, n, start, m;
		last = last_track_for(track_count);
		req = (rq.request_track > last) ? last : rq.request_track;
		if (held_tracks.size() < MAX_REQUESTS) begin
			idx = 0;
			while (idx < held_tracks.size() && held_tracks[idx] <= req)
				idx++;
			held_tracks.insert(idx, req);
		end
		if (rq.batch_end) begin
			order = held_tracks;
			fixed_points[0] = '0;
			fixed_points[1] = head_track;
			fixed_points[2] = last;
			for (f = 0; f < 3; f++) begin
				idx = 0;
				while (idx < order.size() && order[idx] <= fixed_points[f])
					idx++;
				order.insert(idx, fixed_points[f]);
			end
			m = order.size();
			// The head was merged in, so the search always finds it.
			start = 0;
			while (order[start] != head_track)
				start++;
			total = '0;
			prev = order[start];
			for (n = 0; n < m; n++) begin
				cur = order[(start + n) % m];
				step_dist = (cur >= prev) ? cur - prev : prev - cur;
				total = total + TOTAL_W'(step_dist);
				v.visit_track    = cur;
				v.step_distance  = step_dist;
				v.total_movement = total;
				v.final_visit    = (n == m - 1);
				if (keep)
					pending_visits.push_back(v);
				prev = cur;
			end
			held_tracks.delete();
		end
	endtask

	// Offers one request and returns at the edge where it is taken. The
	// sender works in bursts; between bursts valid drops for a random gap.
	// Valid is only lowered at the start of a gap, so back-to-back items
	// keep it high with a single assignment per edge.
	task automatic send_request(input req_item_t rq, input int typed_n);
		int k;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		in_data  <= rq;
		do @(posedge clk); while (!in_ready);
		predict_visits(rq, typed_n == 0);
		for (k = 0; k < typed_n; k++) begin
			pending_visits.push_back(known_visits[known_next]);
			known_next++;
		end
		burst_left--;
	endtask

	// Holds the write offered until it is taken; the caller drops cfg_valid
	// after the last write of a group so that valid never toggles within a step.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HEAD_POSITION: head_track = val[TRACK_W-1:0];
			REG_TRACK_TOTAL:   track_count = val;
			default: ;
		endcase
	endtask

	// Stops the sender, waits for every predicted visit, then lets the unit
	// settle so that no request is still being sorted.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_visits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: switches between always ready, mostly ready, a fixed period
	// and a coin toss, each held for a random stretch.
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_span == 0) begin
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
			rx_span <= $urandom_range(16, 128);
		end else begin
			rx_span <= rx_span - 1;
		end
		case (rx_mode)
			RX_OPEN:     out_ready <= 1'b1;
			RX_SPARSE:   out_ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: out_ready <= (rx_tick % 5 == 0);
			default:     out_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Each visit taken is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_visits.size() == 0) begin
				$display("%0t: unexpected visit track=%h step=%h total=%h final=%b",
					$time, out_data.visit_track, out_data.step_distance,
					out_data.total_movement, out_data.final_visit);
				mismatch_count++;
			end else begin
				want = pending_visits.pop_front();
				if (out_data.visit_track !== want.visit_track
					|| out_data.step_distance !== want.step_distance
					|| out_data.total_movement !== want.total_movement
					|| out_data.final_visit !== want.final_visit) begin
					$display({"%0t: visit mismatch: expected track=%h step=%h total=%h ",
						"final=%b, got track=%h step=%h total=%h final=%b"}, $time,
						want.visit_track, want.step_distance, want.total_movement,
						want.final_visit, out_data.visit_track, out_data.step_distance,
						out_data.total_movement, out_data.final_visit);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		req_item_t          rq;
		logic [TT_W-1:0]    tt;
		logic [TRACK_W-1:0] top, hd;
		int random_items, batches, len, b, i, r;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table. A register row waits for the unit to go idle,
		// unless it follows another register row.
		for (r = 0; r < $size(directed_rows); r++) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				if (!cfg_valid)
					wait_drained();
				write_register(directed_rows[r].reg_index, directed_rows[r].reg_value);
			end else begin
				if (cfg_valid)
					cfg_valid <= 1'b0;
				send_request(directed_rows[r].rq, int'(directed_rows[r].typed_results));
			end
		end

		// Random phases: a fresh setting of both registers, then a few batches.
		// Most batches are short; some fill the memory exactly and some overflow.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			wait_drained();
			case ($urandom_range(0, 9))
				0:       tt = '0;
				1:       tt = TT_W'(1);
				2:       tt = TT_W'(17'h10000);
				3:       tt = '1;
				4, 5:    tt = TT_W'($urandom_range(2, 64));
				default: tt = TT_W'($urandom_range(1, 17'h1FFFF));
			endcase
			top = last_track_for(tt);
			case ($urandom_range(0, 7))
				0:          hd = '0;
				1:          hd = TRACK_TOP;
				2, 3, 4, 5: hd = TRACK_W'($urandom_range(0, top));
				default:    hd = TRACK_W'($urandom);
			endcase
			write_register(REG_TRACK_TOTAL, tt);
			write_register(REG_HEAD_POSITION, {1'b0, hd});
			cfg_valid <= 1'b0;

			batches = $urandom_range(2, 5);
			for (b = 0; b < batches; b++) begin
				case ($urandom_range(0, 7))
					0:       len = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
					1:       len = MAX_REQUESTS;
					default: len = $urandom_range(1, 10);
				endcase
				for (i = 0; i < len; i++) begin
					// Hits on the head and the end tracks exercise duplicates;
					// full-range values saturate when the disk is small.
					case ($urandom_range(0, 9))
						0:       rq.request_track = hd;
						1:       rq.request_track = top;
						2:       rq.request_track = '0;
						3:       rq.request_track = TRACK_W'($urandom);
						default: rq.request_track = TRACK_W'($urandom_range(0, top));
					endcase
					rq.batch_end = (i == len - 1);
					send_request(rq, 0);
					random_items++;
				end
			end
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
